// ===== hw/rtl/dplt_pkg.sv =====
// Shared types and constants for the demand-paging LRU translator.
// Used by dplt_ctrl, dplt_dpath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dplt_pkg;

	localparam int FAULT_BITS = 16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_SCAN,
		ST_COMMIT
	} dplt_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture the address and advance the access stamp
		logic use_entry;  // page is resident: take its frame from the table
		logic take_free;  // claim the lowest free frame
		logic scan_start; // begin the oldest-stamp search
		logic scan_step;  // compare one frame against the current oldest
		logic commit;     // update tables and load the result registers
	} dplt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;
		logic any_free;
		logic scan_last;
	} dplt_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dplt_ctrl.sv =====
// Controller of the translator: sequences lookup, victim search and commit.
// Depends on dplt_pkg for the state type and the command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module dplt_ctrl
	import dplt_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	output logic              busy,
	input  dplt_status_t      status,
	output dplt_cmd_t         cmd
);

	dplt_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (status.hit) begin
					cmd.use_entry = 1'b1;
					state_d       = ST_COMMIT;
				end else if (status.any_free) begin
					cmd.take_free = 1'b1;
					state_d       = ST_COMMIT;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_last) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/dplt_dpath.sv =====
// Datapath of the translator: page table, frame tables, stamp counter,
// victim search registers and result registers. Depends on dplt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dplt_dpath
	import dplt_pkg::*;
#(
	parameter int PAGE_BITS   = 5,
	parameter int FRAME_BITS  = 3,
	parameter int OFFSET_BITS = 7,
	parameter int STAMP_BITS  = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  dplt_cmd_t                              cmd,
	output dplt_status_t                           status,
	input  wire logic [PAGE_BITS+OFFSET_BITS-1:0]  logical_address,
	output logic                                   done,
	output logic [FRAME_BITS+OFFSET_BITS-1:0]      physical_address,
	output logic                                   page_fault,
	output logic                                   evicted,
	output logic [PAGE_BITS-1:0]                   evicted_page,
	output logic [FAULT_BITS-1:0]                  fault_count
);

	localparam int NUM_PAGES  = 1 << PAGE_BITS;
	localparam int NUM_FRAMES = 1 << FRAME_BITS;

	logic [PAGE_BITS+OFFSET_BITS-1:0] la_q;
	logic [STAMP_BITS-1:0]            stamp_q;
	logic [FAULT_BITS-1:0]            faults_q;

	logic [NUM_PAGES-1:0]             valid_q;
	logic [FRAME_BITS-1:0]            entry_frame_q [NUM_PAGES];
	logic [NUM_FRAMES-1:0]            free_q;
	logic [STAMP_BITS-1:0]            last_use_q    [NUM_FRAMES];
	logic [PAGE_BITS-1:0]             owner_q       [NUM_FRAMES];

	logic [FRAME_BITS-1:0]            frame_q;
	logic                             fault_q;
	logic                             evict_q;
	logic [FRAME_BITS-1:0]            idx_q;
	logic [FRAME_BITS-1:0]            best_q;
	logic [STAMP_BITS-1:0]            oldest_q;
	logic                             done_q;

	logic [PAGE_BITS-1:0]             page;
	logic [OFFSET_BITS-1:0]           offset;
	logic [FRAME_BITS-1:0]            free_idx;
	logic                             older;
	logic [PAGE_BITS-1:0]             victim_page;

	assign offset = la_q[OFFSET_BITS-1:0];
	assign page   = la_q[OFFSET_BITS +: PAGE_BITS];

	// lowest free frame above the reserved frame 0
	always_comb begin
		free_idx = '0;
		for (int k = NUM_FRAMES - 1; k >= 1; k--) begin
			if (free_q[k]) begin
				free_idx = FRAME_BITS'(k);
			end
		end
	end

	// a tie moves the choice to the later, higher frame
	assign older       = last_use_q[idx_q] <= oldest_q;
	assign victim_page = owner_q[frame_q];

	assign status.hit       = valid_q[page];
	assign status.any_free  = |free_q[NUM_FRAMES-1:1];
	assign status.scan_last = &idx_q;

	// control and reset-valued state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp_q  <= '0;
			faults_q <= '0;
			valid_q  <= '0;
			free_q   <= {{(NUM_FRAMES-1){1'b1}}, 1'b0};
			for (int k = 0; k < NUM_FRAMES; k++) begin
				last_use_q[k] <= '0;
			end
			done_q   <= 1'b0;
		end else begin
			done_q <= cmd.commit;
			if (cmd.load) begin
				stamp_q <= stamp_q + 1'b1;
			end
			if (cmd.take_free) begin
				free_q[free_idx] <= 1'b0;
			end
			if (cmd.commit) begin
				last_use_q[frame_q] <= stamp_q;
				if (fault_q) begin
					if (evict_q) begin
						valid_q[victim_page] <= 1'b0;
					end
					valid_q[page] <= 1'b1;
					if (faults_q != '1) begin
						faults_q <= faults_q + 1'b1;
					end
				end
			end
		end
	end

	// payload and undefined-until-written stores
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			la_q <= logical_address;
		end
		if (cmd.use_entry) begin
			frame_q <= entry_frame_q[page];
			fault_q <= 1'b0;
			evict_q <= 1'b0;
		end
		if (cmd.take_free) begin
			frame_q <= free_idx;
			fault_q <= 1'b1;
			evict_q <= 1'b0;
		end
		if (cmd.scan_start) begin
			idx_q    <= FRAME_BITS'(1);
			best_q   <= FRAME_BITS'(1);
			oldest_q <= last_use_q[1];
			fault_q  <= 1'b1;
			evict_q  <= 1'b1;
		end
		if (cmd.scan_step) begin
			if (older) begin
				oldest_q <= last_use_q[idx_q];
				best_q   <= idx_q;
			end
			frame_q <= older ? idx_q : best_q;
			idx_q   <= idx_q + 1'b1;
		end
		if (cmd.commit) begin
			if (fault_q) begin
				entry_frame_q[page] <= frame_q;
				owner_q[frame_q]    <= page;
			end
			physical_address <= {frame_q, offset};
			page_fault       <= fault_q;
			evicted          <= evict_q;
			evicted_page     <= evict_q ? victim_page : '0;
			fault_count      <= (fault_q && faults_q != '1) ? faults_q + 1'b1 : faults_q;
		end
	end

	assign done = done_q;

endmodule

`default_nettype wire

// ===== hw/rtl/demand_paging_lru_translator_unit.sv =====
// Top level of the demand-paging LRU translator: controller plus datapath.
// Depends on dplt_pkg, dplt_ctrl and dplt_dpath.
//
//   port group        dir  handshake      contents
//   start/busy        in   start & !busy  logical_address
//   done              out  strobe, 1 cyc  physical_address, page_fault, evicted,
//                                         evicted_page, fault_count
//
// A resident page or a fault with a free frame goes from accept to result
// through accept, lookup and commit. A fault with no free frame adds one scan
// step per frame 1 .. 2**FRAME_BITS-1 for the oldest-stamp search. busy is low
// in the cycle that done is high, so the next item may be taken then. Reset
// clears the page table valid bits, frees frames 1 and up, and zeroes stamps
// and the fault count. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module demand_paging_lru_translator_unit
	import dplt_pkg::*;
#(
	parameter int PAGE_BITS   = 5,
	parameter int FRAME_BITS  = 3,
	parameter int OFFSET_BITS = 7,
	parameter int STAMP_BITS  = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [PAGE_BITS+OFFSET_BITS-1:0]  logical_address,
	output logic                                   done,
	output logic [FRAME_BITS+OFFSET_BITS-1:0]      physical_address,
	output logic                                   page_fault,
	output logic                                   evicted,
	output logic [PAGE_BITS-1:0]                   evicted_page,
	output logic [FAULT_BITS-1:0]                  fault_count
);

	dplt_cmd_t    cmd;
	dplt_status_t status;

	dplt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	dplt_dpath #(
		.PAGE_BITS   (PAGE_BITS),
		.FRAME_BITS  (FRAME_BITS),
		.OFFSET_BITS (OFFSET_BITS),
		.STAMP_BITS  (STAMP_BITS)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.logical_address  (logical_address),
		.done             (done),
		.physical_address (physical_address),
		.page_fault       (page_fault),
		.evicted          (evicted),
		.evicted_page     (evicted_page),
		.fault_count      (fault_count)
	);

endmodule

`default_nettype wire

// ===== sim/dplt_translation_checker.sv =====
// Translation checker for the demand-paging LRU translator testbench.
// Watches the accept and done channels, predicts each translation, compares.
// Depends on dplt_pkg for FAULT_BITS.
`timescale 1ns / 1ps

module dplt_translation_checker
	import dplt_pkg::*;
#(
	parameter int PAGE_BITS   = 5,
	parameter int FRAME_BITS  = 3,
	parameter int OFFSET_BITS = 7,
	parameter int STAMP_BITS  = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             busy,
	input  logic [PAGE_BITS+OFFSET_BITS-1:0] logical_address,
	input  logic                             done,
	input  logic [FRAME_BITS+OFFSET_BITS-1:0] physical_address,
	input  logic                             page_fault,
	input  logic                             evicted,
	input  logic [PAGE_BITS-1:0]             evicted_page,
	input  logic [FAULT_BITS-1:0]            fault_count,
	output int                               mismatches,
	output int                               outstanding
);

	localparam int NUM_PAGES  = 1 << PAGE_BITS;
	localparam int NUM_FRAMES = 1 << FRAME_BITS;

	typedef struct packed {
		logic [FRAME_BITS+OFFSET_BITS-1:0] phys;
		logic                              fault;
		logic                              evict;
		logic [PAGE_BITS-1:0]              evict_page;
		logic [FAULT_BITS-1:0]             faults;
	} xlate_t;

	logic                   page_resident [NUM_PAGES];
	logic [FRAME_BITS-1:0]  page_frame    [NUM_PAGES];
	logic                   frame_unused  [NUM_FRAMES];
	logic [STAMP_BITS-1:0]  frame_stamp   [NUM_FRAMES];
	logic [PAGE_BITS-1:0]   frame_page    [NUM_FRAMES];
	logic [STAMP_BITS-1:0]  access_stamp;
	logic [FAULT_BITS-1:0]  faults_total;
	xlate_t                 pending_xlates [$];

	task automatic clear_tables();
		for (int p = 0; p < NUM_PAGES; p++) begin
			page_resident[p] = 1'b0;
			page_frame[p] = '0;
		end
		for (int f = 0; f < NUM_FRAMES; f++) begin
			frame_unused[f] = (f != 0);
			frame_stamp[f] = '0;
			frame_page[f] = '0;
		end
		access_stamp = '0;
		faults_total = '0;
	endtask

	task automatic translate(input logic [PAGE_BITS+OFFSET_BITS-1:0] la, output xlate_t res);
		logic [OFFSET_BITS-1:0] offset;
		logic [PAGE_BITS-1:0]   page;
		logic [FRAME_BITS-1:0]  frame;
		logic [STAMP_BITS-1:0]  oldest;
		offset = la[OFFSET_BITS-1:0];
		page = la[PAGE_BITS+OFFSET_BITS-1:OFFSET_BITS];
		res = '0;
		access_stamp = access_stamp + 1'b1;
		if (page_resident[page]) begin
			frame = page_frame[page];
		end else begin
			frame = '0;
			for (int f = 1; f < NUM_FRAMES; f++) begin
				if (frame == '0 && frame_unused[f]) begin
					frame = FRAME_BITS'(f);
				end
			end
			if (frame != '0) begin
				frame_unused[frame] = 1'b0;
			end else begin
				// oldest stamp wins; on a tie the highest frame index
				oldest = frame_stamp[1];
				frame = FRAME_BITS'(1);
				for (int f = 1; f < NUM_FRAMES; f++) begin
					if (frame_stamp[f] <= oldest) begin
						oldest = frame_stamp[f];
						frame = FRAME_BITS'(f);
					end
				end
				res.evict = 1'b1;
				res.evict_page = frame_page[frame];
				page_resident[frame_page[frame]] = 1'b0;
			end
			page_frame[page] = frame;
			page_resident[page] = 1'b1;
			frame_page[frame] = page;
			res.fault = 1'b1;
			if (faults_total != '1) begin
				faults_total = faults_total + 1'b1;
			end
		end
		frame_stamp[frame] = access_stamp;
		res.phys = {frame, offset};
		res.faults = faults_total;
	endtask

	always @(posedge clk) begin
		xlate_t want;
		xlate_t got;
		if (!arst_n) begin
			clear_tables();
			pending_xlates.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			// retire the result first: an item accepted now is younger
			if (done) begin
				got = '{physical_address, page_fault, evicted, evicted_page, fault_count};
				if (pending_xlates.size() == 0) begin
					if (mismatches < 10) begin
						$display("%0t: unexpected item pa=%h pf=%b ev=%b evp=%h fc=%0d",
							$time, got.phys, got.fault, got.evict, got.evict_page,
							got.faults);
					end
					mismatches++;
				end else begin
					want = pending_xlates.pop_front();
					if (got.phys !== want.phys || got.fault !== want.fault ||
							got.evict !== want.evict || got.evict_page !== want.evict_page ||
							got.faults !== want.faults) begin
						if (mismatches < 10) begin
							$display("%0t: mismatch expected pa=%h pf=%b ev=%b evp=%h fc=%0d",
								$time, want.phys, want.fault, want.evict, want.evict_page,
								want.faults);
							$display("%0t:          actual   pa=%h pf=%b ev=%b evp=%h fc=%0d",
								$time, got.phys, got.fault, got.evict, got.evict_page,
								got.faults);
						end
						mismatches++;
					end
				end
			end
			if (start && !busy) begin
				translate(logical_address, want);
				pending_xlates.push_back(want);
			end
			outstanding = pending_xlates.size();
		end
	end

endmodule

// ===== sim/demand_paging_lru_translator_unit_test.sv =====
// Testbench top for the demand-paging LRU translator: clock, reset, stimulus
// and verdict. Depends on dplt_pkg, demand_paging_lru_translator_unit and
// dplt_translation_checker.
`timescale 1ns / 1ps

module demand_paging_lru_translator_unit_test;
	import dplt_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 30;
	localparam int HOT_PAGES     = 9;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic [11:0]           logical_address = '0;
	logic                  busy;
	logic                  done;
	logic [9:0]            physical_address;
	logic                  page_fault;
	logic                  evicted;
	logic [4:0]            evicted_page;
	logic [FAULT_BITS-1:0] fault_count;
	int                    mismatches;
	int                    outstanding;
	int                    cycles = 0;

	demand_paging_lru_translator_unit uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.logical_address  (logical_address),
		.done             (done),
		.physical_address (physical_address),
		.page_fault       (page_fault),
		.evicted          (evicted),
		.evicted_page     (evicted_page),
		.fault_count      (fault_count)
	);

	dplt_translation_checker xlate_chk (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.logical_address  (logical_address),
		.done             (done),
		.physical_address (physical_address),
		.page_fault       (page_fault),
		.evicted          (evicted),
		.evicted_page     (evicted_page),
		.fault_count      (fault_count),
		.mismatches       (mismatches),
		.outstanding      (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Present one item after an optional gap and return at the edge that takes it.
	task automatic send_item(input logic [11:0] la, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		logical_address <= la;
		do @(posedge clk); while (busy);
	endtask

	// Hold off until every translation in flight has come back.
	task automatic wait_drained();
		start <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
	endtask

	task automatic run_phase(input int idle_pct, input int count);
		logic [4:0]  hot [HOT_PAGES];
		logic [11:0] la;
		int          gap;
		for (int k = 0; k < HOT_PAGES; k++) begin
			hot[k] = 5'($urandom_range(31));
		end
		for (int n = 0; n < count; n++) begin
			// mostly a working set a bit larger than the frame pool: hits and evictions
			if ($urandom_range(99) < 75) begin
				la = {hot[$urandom_range(HOT_PAGES - 1)], 7'($urandom_range(127))};
			end else begin
				la = 12'($urandom_range(4095));
			end
			gap = 0;
			while (gap < 20 && $urandom_range(99) < idle_pct) begin
				gap++;
			end
			send_item(la, gap);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// fill the frame pool, then evict through it
		send_item(12'h000, 0);
		send_item(12'hFFF, 0);
		send_item(12'h07F, 1);
		send_item(12'h080, 0);
		send_item(12'h155, 2);
		send_item(12'h2AA, 0);
		send_item(12'hD2A, 0);
		send_item(12'hF80, 0);
		send_item(12'h800, 1);
		send_item(12'h400, 0);
		send_item(12'h001, 0);
		send_item(12'h3FF, 3);
		send_item(12'h7FF, 0);
		send_item(12'hBFF, 0);
		send_item(12'hF00, 0);
		send_item(12'h87F, 1);
		send_item(12'hFFF, 0);
		send_item(12'h555, 0);
		send_item(12'hAAA, 0);
		send_item(12'h7F0, 0);
		send_item(12'h0C3, 0);
		send_item(12'h400, 0);

		run_phase(0, 100);
		run_phase(60, 100);
		wait_drained();
		run_phase(0, 100);
		run_phase(24, 100);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/dplt_pkg.sv
hw/rtl/dplt_ctrl.sv
hw/rtl/dplt_dpath.sv
hw/rtl/demand_paging_lru_translator_unit.sv
sim/dplt_translation_checker.sv
sim/demand_paging_lru_translator_unit_test.sv
